// File: rtl/dswl_pkg.sv
// package for the serial tuning word loader
// holds command codes, slot counts and the pin level struct; no dependencies
package dswl_pkg;

    localparam int unsigned DEF_WORD_BITS = 32;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned STEP_W    = 7;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned TUNE_W    = 32;
    localparam int unsigned OUT_W     = 8;

    localparam logic [OP_W-1:0] KIND_IDLE  = 2'd0;
    localparam logic [OP_W-1:0] KIND_RESET = 2'd1;
    localparam logic [OP_W-1:0] KIND_LOAD  = 2'd2;
    localparam logic [OP_W-1:0] KIND_WRITE = 2'd3;

    localparam int unsigned RESET_PULSES   = 10;
    localparam int unsigned TRAILER_PULSES = 8;

    localparam logic [STEP_W-1:0] RESET_SLOTS = STEP_W'(1 + 2 * RESET_PULSES);
    localparam logic [STEP_W-1:0] LOAD_SLOTS  = 7'd16;

    // load enable timing
    localparam logic [STEP_W-1:0] LOAD_WCLK_END  = 7'd2;
    localparam logic [STEP_W-1:0] LOAD_UPD_BEGIN = 7'd12;
    localparam logic [STEP_W-1:0] LOAD_UPD_END   = 7'd14;

    localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd5;

    typedef struct packed {
        logic rst;
        logic upd;
        logic data;
        logic wclk;
    } t_pins;

endpackage

// File: rtl/dswl_pins.sv
// slot decoder: pin levels for one slot of the running sequence
// depends on dswl_pkg
module dswl_pins #(
    parameter int unsigned WORD_BITS = dswl_pkg::DEF_WORD_BITS
) (
    input  logic [dswl_pkg::OP_W-1:0]   i_kind,
    input  logic [dswl_pkg::STEP_W-1:0] i_step,
    input  logic [WORD_BITS-1:0]        i_word,
    input  logic                        i_prev_data,
    output dswl_pkg::t_pins             o_pins
);
    import dswl_pkg::*;

    localparam int unsigned BIT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [STEP_W-1:0] DATA_SLOTS  = STEP_W'(2 * WORD_BITS);
    localparam logic [STEP_W-1:0] TRAIL_END   = STEP_W'(2 * WORD_BITS + 2 * TRAILER_PULSES);
    localparam logic [STEP_W-1:0] UPD_BEGIN   = STEP_W'(2 * WORD_BITS + 2 * TRAILER_PULSES + 2);
    localparam logic [STEP_W-1:0] UPD_END     = STEP_W'(2 * WORD_BITS + 2 * TRAILER_PULSES + 4);

    logic [BIT_W-1:0] bit_idx;

    assign bit_idx = i_step[BIT_W:1];

    always_comb begin
        o_pins = '0;
        case (i_kind)
            KIND_RESET: begin
                o_pins.rst  = 1'b1;
                o_pins.data = i_prev_data;
                // first slot is low, then pulses high on even slots
                o_pins.wclk = (i_step != '0) && !i_step[0];
            end
            KIND_LOAD: begin
                o_pins.data = i_prev_data;
                o_pins.wclk = i_step < LOAD_WCLK_END;
                o_pins.upd  = (i_step >= LOAD_UPD_BEGIN) && (i_step < LOAD_UPD_END);
            end
            KIND_WRITE: begin
                if (i_step < DATA_SLOTS) begin
                    o_pins.data = i_word[bit_idx];
                    o_pins.wclk = i_step[0];
                end else if (i_step < TRAIL_END) begin
                    o_pins.wclk = i_step[0];
                end else begin
                    o_pins.upd = (i_step >= UPD_BEGIN) && (i_step < UPD_END);
                end
            end
            default: begin
                o_pins.data = i_prev_data;
            end
        endcase
    end

endmodule

// File: rtl/dds_serial_word_loader.sv
// Serial load pin sequencer for a direct digital synthesizer.
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while results are taken; the sequencer state and
// pin decode settle between the state registers and the result register. A waiting
// result holds off the input, which is taken again in the cycle that result leaves.
// Reset: synchronous active low; sequencer idle, held data level low, no result waiting, half period 5.
module dds_serial_word_loader #(
    parameter int unsigned WORD_BITS = dswl_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write: half_period_ticks
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dswl_pkg::TICK_W-1:0]   i_cfg_data,
    // input beat
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dswl_pkg::TUNE_W-1:0]   i_s_axis_tdata,  // [31:0] tuning_word
    input  logic [dswl_pkg::OP_W-1:0]     i_s_axis_tuser,  // [1:0] op
    // result beat
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] wclk_level, [1] data_level, [2] update_level, [3] reset_level,
    // [4] busy_res, [5] rejected, [7:6] zero
    output logic [dswl_pkg::OUT_W-1:0]    o_m_axis_tdata
);
    import dswl_pkg::*;

    localparam logic [STEP_W-1:0] WRITE_SLOTS =
        STEP_W'(2 * WORD_BITS + 2 * TRAILER_PULSES + 6);

    logic [TICK_W-1:0]    r_half_period;
    logic [OP_W-1:0]      r_kind;
    logic [STEP_W-1:0]    r_step;
    logic [TICK_W-1:0]    r_tick;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_data;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out;

    logic                 accept;
    logic                 cmd;
    logic                 start;
    logic                 rej;
    logic [OP_W-1:0]      kind_c;
    logic [STEP_W-1:0]    step_c;
    logic [TICK_W-1:0]    tick_c;
    logic [WORD_BITS-1:0] word_c;
    logic                 busy;
    t_pins                seq_pins;
    t_pins                out_pins;
    logic [TICK_W-1:0]    half_eff;
    logic                 slot_end;
    logic [STEP_W-1:0]    step_inc;
    logic [STEP_W-1:0]    slot_total;
    logic                 seq_done;

    logic [OP_W-1:0]      n_kind;
    logic [STEP_W-1:0]    n_step;
    logic [TICK_W-1:0]    n_tick;
    logic                 n_data;
    logic [OUT_W-1:0]     n_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd    = i_s_axis_tuser != KIND_IDLE;
    assign start  = cmd && (r_kind == KIND_IDLE);
    assign rej    = cmd && (r_kind != KIND_IDLE);

    assign kind_c = start ? i_s_axis_tuser : r_kind;
    assign step_c = start ? '0 : r_step;
    assign tick_c = start ? '0 : r_tick;
    assign word_c = start ? i_s_axis_tdata[WORD_BITS-1:0] : r_word;
    assign busy   = kind_c != KIND_IDLE;

    dswl_pins #(
        .WORD_BITS (WORD_BITS)
    ) u_pins (
        .i_kind      (kind_c),
        .i_step      (step_c),
        .i_word      (word_c),
        .i_prev_data (r_data),
        .o_pins      (seq_pins)
    );

    // zero half period runs as one tick per slot
    assign half_eff = (r_half_period == '0) ? TICK_W'(1) : r_half_period;
    assign slot_end = ({1'b0, tick_c} + 17'd1) >= {1'b0, half_eff};
    assign step_inc = step_c + 7'd1;

    always_comb begin
        case (kind_c)
            KIND_RESET: slot_total = RESET_SLOTS;
            KIND_LOAD:  slot_total = LOAD_SLOTS;
            KIND_WRITE: slot_total = WRITE_SLOTS;
            default:    slot_total = '0;
        endcase
    end

    assign seq_done = step_inc >= slot_total;

    always_comb begin
        n_kind   = kind_c;
        n_step   = step_c;
        n_tick   = tick_c;
        n_data   = r_data;
        out_pins = '{rst: 1'b0, upd: 1'b0, data: r_data, wclk: 1'b0};
        if (busy) begin
            out_pins = seq_pins;
            n_data   = seq_pins.data;
            if (slot_end) begin
                n_tick = '0;
                if (seq_done) begin
                    n_kind = KIND_IDLE;
                    n_step = '0;
                end else begin
                    n_step = step_inc;
                end
            end else begin
                n_tick = tick_c + 16'd1;
            end
        end
        n_out = {2'b00, rej, busy, out_pins.rst, out_pins.upd, out_pins.data, out_pins.wclk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half_period <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_IDLE;
            r_step      <= '0;
            r_tick      <= '0;
            r_data      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_kind      <= n_kind;
                r_step      <= n_step;
                r_tick      <= n_tick;
                r_data      <= n_data;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= word_c;
            r_out  <= n_out;
        end
    end

    // a rejected command only happens while a sequence runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out[5] |-> r_out[4])
        else $error("rejected result without busy");

    // clock, update and reset pins are low whenever no sequence runs
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out[4] |-> (r_out[0] == 1'b0) && (r_out[2] == 1'b0)
                                      && (r_out[3] == 1'b0))
        else $error("pins active while idle");

    // an idle sequencer always rests at slot zero, tick zero
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind == KIND_IDLE |-> (r_step == '0) && (r_tick == '0))
        else $error("idle sequencer with stale counters");

    // the slot counter never runs past the longest sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < WRITE_SLOTS)
        else $error("slot index out of range");

endmodule

// File: tb/sv/tb.sv
// self-checking bench for dds_serial_word_loader: drives tick and command beats,
// predicts the pin levels of every tick and checks each result beat
// depends on rtl/dswl_pkg.sv and rtl/dds_serial_word_loader.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dswl_pkg::*;

    localparam int unsigned WORD_BITS      = DEF_WORD_BITS;
    localparam int unsigned WRITE_SLOTS    = 2 * WORD_BITS + 2 * TRAILER_PULSES + 6;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 4;

    typedef struct {
        t_pins pins;
        logic  busy;
        logic  rejected;
    } t_tick_result;

    // predicts the pin levels of every tick and checks the result beats
    class pin_scoreboard;
        logic [TICK_W-1:0] slot_ticks = HALF_PERIOD_RESET;
        logic [TUNE_W-1:0] word_sr    = '0;
        logic [OP_W-1:0]   seq_kind   = KIND_IDLE;
        logic [STEP_W-1:0] slot       = '0;
        logic [TICK_W-1:0] tick_cnt   = '0;
        t_pins             levels     = '0;
        t_tick_result      expected_ticks[$];
        int                errors     = 0;

        function int unsigned slot_count(logic [OP_W-1:0] kind);
            case (kind)
                KIND_RESET: return RESET_SLOTS;
                KIND_LOAD:  return LOAD_SLOTS;
                KIND_WRITE: return WRITE_SLOTS;
                default:    return 0;
            endcase
        endfunction

        function t_pins slot_pins(logic [OP_W-1:0] kind, logic [STEP_W-1:0] s, t_pins prev);
            t_pins       p;
            int unsigned bits;
            bits   = 2 * WORD_BITS;
            p      = '0;
            p.data = prev.data;
            case (kind)
                KIND_RESET: begin
                    p.rst  = 1'b1;
                    p.wclk = (s != 0) && !s[0];
                end
                KIND_LOAD: begin
                    p.wclk = s < LOAD_WCLK_END;
                    p.upd  = (s >= LOAD_UPD_BEGIN) && (s < LOAD_UPD_END);
                end
                KIND_WRITE: begin
                    p = '0;
                    if (s < bits) begin
                        p.data = word_sr[s >> 1];
                        p.wclk = s[0];
                    end else if (s < bits + 2 * TRAILER_PULSES) begin
                        p.wclk = s[0];
                    end else if (s >= bits + 2 * TRAILER_PULSES + 2 &&
                                 s < bits + 2 * TRAILER_PULSES + 4) begin
                        p.upd = 1'b1;
                    end
                end
                default: p = prev;
            endcase
            return p;
        endfunction

        function void set_slot_ticks(logic [TICK_W-1:0] value);
            slot_ticks = value;
        endfunction

        function bit busy();
            return seq_kind != KIND_IDLE;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // one accepted input beat: one tick, maybe a command
        function void take_command(logic [OP_W-1:0] op, logic [TUNE_W-1:0] word);
            t_tick_result r;
            int unsigned  h;
            r.rejected = 1'b0;
            if (op != KIND_IDLE) begin
                if (seq_kind != KIND_IDLE) begin
                    r.rejected = 1'b1;
                end else begin
                    seq_kind = op;
                    slot     = '0;
                    tick_cnt = '0;
                    word_sr  = word;
                end
            end
            r.busy = seq_kind != KIND_IDLE;
            if (r.busy) begin
                h      = (slot_ticks == 0) ? 1 : slot_ticks;
                levels = slot_pins(seq_kind, slot, levels);
                r.pins = levels;
                if (int'(tick_cnt) + 1 >= h) begin
                    tick_cnt = '0;
                    slot     = slot + 1'b1;
                    if (slot >= slot_count(seq_kind)) begin
                        seq_kind = KIND_IDLE;
                        slot     = '0;
                        levels   = '{rst: 1'b0, upd: 1'b0, data: levels.data, wclk: 1'b0};
                    end
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                end
            end else begin
                r.pins = levels;
            end
            expected_ticks.push_back(r);
        endfunction

        function void check_pins(logic [OUT_W-1:0] beat);
            t_tick_result e;
            if (expected_ticks.size() == 0) begin
                $error("result beat 0x%02h with no tick waiting", beat);
                errors++;
                return;
            end
            e = expected_ticks.pop_front();
            if (beat[0] !== e.pins.wclk) begin
                $error("wclk_level: expected %0d, got %0d", e.pins.wclk, beat[0]);
                errors++;
            end
            if (beat[1] !== e.pins.data) begin
                $error("data_level: expected %0d, got %0d", e.pins.data, beat[1]);
                errors++;
            end
            if (beat[2] !== e.pins.upd) begin
                $error("update_level: expected %0d, got %0d", e.pins.upd, beat[2]);
                errors++;
            end
            if (beat[3] !== e.pins.rst) begin
                $error("reset_level: expected %0d, got %0d", e.pins.rst, beat[3]);
                errors++;
            end
            if (beat[4] !== e.busy) begin
                $error("busy_res: expected %0d, got %0d", e.busy, beat[4]);
                errors++;
            end
            if (beat[5] !== e.rejected) begin
                $error("rejected: expected %0d, got %0d", e.rejected, beat[5]);
                errors++;
            end
            if (beat[7:6] !== 2'b00) begin
                $error("pad: expected 0, got %0d", beat[7:6]);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [TICK_W-1:0]  i_cfg_data      = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TUNE_W-1:0]  i_s_axis_tdata  = '0;  // [31:0] tuning_word
    logic [OP_W-1:0]    i_s_axis_tuser  = KIND_IDLE;  // [1:0] op
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;  // [3:0] wclk/data/update/reset, [4] busy, [5] rejected

    pin_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    dds_serial_word_loader #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check each beat, random stalls and one long hold-off on request
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pins(o_m_axis_tdata);
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_tick(logic [OP_W-1:0] op, logic [TUNE_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_command(op, word);
    endtask

    // tick until the running sequence has ended
    task automatic run_out();
        while (sb.busy())
            send_tick(KIND_IDLE, $urandom);
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_period(logic [TICK_W-1:0] value);
        run_out();
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_slot_ticks(value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_ticks(int n, bit with_pressure);
        logic [OP_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            if (with_pressure && i == n / 3)
                drain_results();
            if (with_pressure && i == n / 2)
                hold_req = 1'b1;
            op = KIND_IDLE;
            if ($urandom_range(0, 99) < 8)
                case ($urandom_range(0, 2))
                    0:       op = KIND_RESET;
                    1:       op = KIND_LOAD;
                    default: op = KIND_WRITE;
                endcase
            send_tick(op, $urandom);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 59;
        write_half_period(16'd1);

        // directed: all commands, rejects while busy, word extremes
        send_tick(KIND_IDLE, 32'h0000_0000);
        send_tick(KIND_IDLE, 32'hFFFF_FFFF);
        send_tick(KIND_WRITE, 32'hFFFF_FFFF);
        send_tick(KIND_RESET, 32'h0000_0000);
        send_tick(KIND_LOAD, 32'h1234_5678);
        send_tick(KIND_WRITE, 32'h0000_0000);
        run_out();
        // data pin keeps its last level through reset and load
        send_tick(KIND_RESET, 32'h0000_0000);
        send_tick(KIND_RESET, 32'hFFFF_FFFF);
        run_out();
        send_tick(KIND_LOAD, 32'hFFFF_FFFF);
        run_out();
        send_tick(KIND_WRITE, 32'h0000_0000);
        run_out();
        send_tick(KIND_LOAD, 32'h0000_0000);
        run_out();
        send_tick(KIND_WRITE, 32'h8000_0001);
        send_tick(KIND_LOAD, 32'h8000_0001);
        run_out();
        send_tick(KIND_WRITE, 32'h5555_AAAA);
        run_out();

        random_ticks(500, 1'b1);

        send_idle_pct = 59;
        recv_idle_pct = 11;
        write_half_period(16'd3);
        random_ticks(500, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_half_period(16'd2);
        random_ticks(500, 1'b0);

        // longest slots: only the tick counter moves within the run
        write_half_period(16'hFFFF);
        send_tick(KIND_WRITE, $urandom);
        send_tick(KIND_LOAD, $urandom);
        random_ticks(150, 1'b0);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
